FILE: hdl/btsp_pkg.sv
// Package with the phase codes, record kinds and record layout of the bouquet table parser.
package btsp_pkg;

	localparam int PHASE_W = 4;
	localparam int POS_W   = 4;
	localparam int LEN_W   = 12;
	localparam int ID_W    = 16;
	localparam int KIND_W  = 2;

	// Parser phases.
	localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_FIXED    = 4'd1;
	localparam logic [PHASE_W-1:0] PH_BQ_DESC  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_LOOP_HI  = 4'd3;
	localparam logic [PHASE_W-1:0] PH_LOOP_LO  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ENTRY0   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_ENTRY1   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_ENTRY2   = 4'd7;
	localparam logic [PHASE_W-1:0] PH_ENTRY3   = 4'd8;
	localparam logic [PHASE_W-1:0] PH_ENTRY4   = 4'd9;
	localparam logic [PHASE_W-1:0] PH_ENTRY5   = 4'd10;
	localparam logic [PHASE_W-1:0] PH_ENT_DESC = 4'd11;
	localparam logic [PHASE_W-1:0] PH_DONE     = 4'd12;

	// Byte positions inside the fixed section header.
	localparam logic [POS_W-1:0] POS_START  = 4'd1;
	localparam logic [POS_W-1:0] POS_BID_HI = 4'd3;
	localparam logic [POS_W-1:0] POS_BID_LO = 4'd4;
	localparam logic [POS_W-1:0] POS_LEN_HI = 4'd8;
	localparam logic [POS_W-1:0] POS_LEN_LO = 4'd9;

	localparam logic [LEN_W:0] ENTRY_BYTES = 13'd6;

	// Record kinds.
	localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OVERRUN = 2'd3;

	// Result payload; the last field sits in the lowest bits.
	typedef struct packed {
		logic [LEN_W-1:0] loop_length;
		logic [LEN_W-1:0] descriptor_length;
		logic [ID_W-1:0]  network_id;
		logic [ID_W-1:0]  stream_id;
		logic [ID_W-1:0]  bouquet_id;
	} rec_t;

endpackage

FILE: hdl/bouquet_table_section_parser.sv
// Top level of the bouquet association table section parser.
//
// The slave channel takes one section byte per item: s_tdata carries the byte and
// s_tuser flags the table id byte that opens a new section. A flagged byte always
// restarts parsing, abandoning any section in progress.
// The master channel delivers records: a bouquet header (with the low loop length
// byte), one record per transport stream entry (with the sixth entry byte), a loop
// finished record (with the first CRC byte), or an overrun record when an entry
// runs past the loop length, after which the section is ignored.
// An accepted byte sits in the input register and is parsed from there into the
// result register, which drives m_tvalid. The throughput is one byte per cycle
// while the receiver does not stall, set by the single phase update per byte.
// Most bytes produce no record; those simply leave the result register empty.
// When the receiver stalls, the record waits in the result register, the input
// register fills, and s_tready drops until the record is taken; nothing is lost.
// Reset clears the valid flags and puts the parser in its idle phase, where all
// bytes are ignored until a flagged first byte arrives.
module bouquet_table_section_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [15:0] bouquet_id, [31:16] stream_id,
	                               // [47:32] network_id, [59:48] descriptor_length,
	                               // [71:60] loop_length
	output logic [1:0]  m_tuser    // [1:0] record_kind
);

	localparam int LW = btsp_pkg::LEN_W;
	localparam int IW = btsp_pkg::ID_W;

	// Input register.
	logic       s1_valid_q;
	logic [7:0] s1_byte_q;
	logic       s1_first_q;

	// Parser state.
	logic [btsp_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [btsp_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [LW-1:0]                skip_q, skip_d;
	logic [LW-1:0]                loop_q, loop_d;
	logic [IW-1:0]                bid_q, bid_d;
	logic [IW-1:0]                sid_q, sid_d;
	logic [IW-1:0]                nid_q, nid_d;
	logic [LW-1:0]                hlen_q, hlen_d;

	// Result register.
	logic                          out_valid_q;
	btsp_pkg::rec_t                out_rec_q;
	logic [btsp_pkg::KIND_W-1:0]   out_kind_q;

	logic                        advance, proc;
	logic                        emit;
	logic [btsp_pkg::KIND_W-1:0] kind_d;
	btsp_pkg::rec_t              rec_d;
	logic [LW-1:0]               ent_len;
	logic [LW:0]                 ent_need;
	logic [LW-1:0]               skip_dec;

	// The result register can take a new value when it is empty or being drained.
	assign advance  = !out_valid_q || m_tready;
	assign proc     = s1_valid_q && advance;
	assign s_tready = !s1_valid_q || advance;

	assign ent_len  = {hlen_q[LW-1:8], s1_byte_q};
	assign ent_need = {1'b0, ent_len} + btsp_pkg::ENTRY_BYTES;
	assign skip_dec = skip_q - {{(LW-1){1'b0}}, 1'b1};

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		skip_d  = skip_q;
		loop_d  = loop_q;
		bid_d   = bid_q;
		sid_d   = sid_q;
		nid_d   = nid_q;
		hlen_d  = hlen_q;
		emit    = 1'b0;
		kind_d  = btsp_pkg::KIND_HEADER;
		rec_d   = '0;
		if (s1_first_q) begin
			phase_d = btsp_pkg::PH_FIXED;
			pos_d   = btsp_pkg::POS_START;
			skip_d  = '0;
			loop_d  = '0;
			bid_d   = '0;
			sid_d   = '0;
			nid_d   = '0;
			hlen_d  = '0;
		end else begin
			case (phase_q)
				btsp_pkg::PH_FIXED: begin
					if (pos_q == btsp_pkg::POS_BID_HI) begin
						bid_d = {s1_byte_q, 8'h00};
					end else if (pos_q == btsp_pkg::POS_BID_LO) begin
						bid_d = {bid_q[IW-1:8], s1_byte_q};
					end else if (pos_q == btsp_pkg::POS_LEN_HI) begin
						hlen_d = {s1_byte_q[3:0], 8'h00};
					end else if (pos_q == btsp_pkg::POS_LEN_LO) begin
						hlen_d  = {hlen_q[LW-1:8], s1_byte_q};
						skip_d  = hlen_d;
						phase_d = (hlen_d != '0) ? btsp_pkg::PH_BQ_DESC
						                         : btsp_pkg::PH_LOOP_HI;
					end
					pos_d = pos_q + {{(btsp_pkg::POS_W-1){1'b0}}, 1'b1};
				end
				btsp_pkg::PH_BQ_DESC: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = btsp_pkg::PH_LOOP_HI;
					end
				end
				btsp_pkg::PH_LOOP_HI: begin
					loop_d  = {s1_byte_q[3:0], 8'h00};
					phase_d = btsp_pkg::PH_LOOP_LO;
				end
				btsp_pkg::PH_LOOP_LO: begin
					loop_d  = {loop_q[LW-1:8], s1_byte_q};
					phase_d = btsp_pkg::PH_ENTRY0;
					emit    = 1'b1;
					kind_d  = btsp_pkg::KIND_HEADER;
					rec_d.bouquet_id        = bid_q;
					rec_d.descriptor_length = hlen_q;
					rec_d.loop_length       = loop_d;
				end
				btsp_pkg::PH_ENTRY0: begin
					if (loop_q == '0) begin
						phase_d = btsp_pkg::PH_DONE;
						emit    = 1'b1;
						kind_d  = btsp_pkg::KIND_DONE;
						rec_d.bouquet_id = bid_q;
					end else begin
						sid_d   = {s1_byte_q, 8'h00};
						phase_d = btsp_pkg::PH_ENTRY1;
					end
				end
				btsp_pkg::PH_ENTRY1: begin
					sid_d   = {sid_q[IW-1:8], s1_byte_q};
					phase_d = btsp_pkg::PH_ENTRY2;
				end
				btsp_pkg::PH_ENTRY2: begin
					nid_d   = {s1_byte_q, 8'h00};
					phase_d = btsp_pkg::PH_ENTRY3;
				end
				btsp_pkg::PH_ENTRY3: begin
					nid_d   = {nid_q[IW-1:8], s1_byte_q};
					phase_d = btsp_pkg::PH_ENTRY4;
				end
				btsp_pkg::PH_ENTRY4: begin
					hlen_d  = {s1_byte_q[3:0], 8'h00};
					phase_d = btsp_pkg::PH_ENTRY5;
				end
				btsp_pkg::PH_ENTRY5: begin
					hlen_d = ent_len;
					emit   = 1'b1;
					rec_d.bouquet_id        = bid_q;
					rec_d.stream_id         = sid_q;
					rec_d.network_id        = nid_q;
					rec_d.descriptor_length = ent_len;
					rec_d.loop_length       = loop_q;
					// The entry header plus its descriptors must fit in what is left.
					if ({1'b0, loop_q} < ent_need) begin
						phase_d = btsp_pkg::PH_DONE;
						kind_d  = btsp_pkg::KIND_OVERRUN;
					end else begin
						kind_d  = btsp_pkg::KIND_ENTRY;
						loop_d  = loop_q - ent_need[LW-1:0];
						skip_d  = ent_len;
						phase_d = (ent_len != '0) ? btsp_pkg::PH_ENT_DESC
						                          : btsp_pkg::PH_ENTRY0;
					end
				end
				btsp_pkg::PH_ENT_DESC: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = btsp_pkg::PH_ENTRY0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			s1_byte_q  <= s_tdata;
			s1_first_q <= s_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= btsp_pkg::PH_IDLE;
			pos_q   <= '0;
			skip_q  <= '0;
			loop_q  <= '0;
			bid_q   <= '0;
			sid_q   <= '0;
			nid_q   <= '0;
			hlen_q  <= '0;
		end else if (proc) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			skip_q  <= skip_d;
			loop_q  <= loop_d;
			bid_q   <= bid_d;
			sid_q   <= sid_d;
			nid_q   <= nid_d;
			hlen_q  <= hlen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_rec_q  <= rec_d;
			out_kind_q <= kind_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_rec_q;
	assign m_tuser  = out_kind_q;

	// A stalled input byte must not be consumed or overwritten.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_first_q))
		else $error("input register changed while stalled");

	// The phase never leaves the defined range.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= btsp_pkg::PH_DONE)
		else $error("parser phase out of range");

	// A header record always starts the entry loop.
	a_header_next: assert property (@(posedge clk) disable iff (!arst_n)
		proc && emit && kind_d == btsp_pkg::KIND_HEADER && !s1_first_q
		|=> phase_q == btsp_pkg::PH_ENTRY0)
		else $error("header record without entering the entry loop");

	// Loop finished and overrun records end the section.
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		proc && emit && (kind_d == btsp_pkg::KIND_DONE || kind_d == btsp_pkg::KIND_OVERRUN)
		|=> phase_q == btsp_pkg::PH_DONE)
		else $error("closing record without ending the section");

	// A loop finished record carries nothing but the bouquet id.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == btsp_pkg::KIND_DONE
		|-> m_tdata[71:16] == '0)
		else $error("loop finished record has nonzero entry fields");

endmodule
